### sv/five_voice_sine_synth_macros.svh
// Assertion macros shared by the synth checker.
`ifndef FIVE_VOICE_SINE_SYNTH_MACROS_SVH
`define FIVE_VOICE_SINE_SYNTH_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define FVS_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define FVS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/fvs_pkg.sv
// Shared types, constants and the quarter-wave sine table of the sine synth.
package fvs_pkg;

   // voices and input packing
   localparam int VOICES     = 5;
   localparam int INC_FIELDS = 5;
   localparam int INC_W      = 31;
   localparam int TICK_W     = 18;
   localparam int PHASE_W    = 32;
   localparam int AMP_W      = 12;
   localparam int LEVEL_W    = 16;

   localparam int REQ_TICK_LSB = INC_FIELDS * INC_W;
   localparam int REQ_SPAN_LSB = REQ_TICK_LSB + TICK_W;
   localparam int REQ_BITS     = REQ_SPAN_LSB + TICK_W;
   localparam int REQ_DATA_W   = ((REQ_BITS + 7) / 8) * 8;
   localparam int REQ_USER_W   = 1;
   localparam int SAMPLE_W     = 16;

   // config port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   typedef enum logic [0:0] {
      CSR_AMP_NORMAL = 1'b0,
      CSR_AMP_LOUD   = 1'b1
   } csr_reg_type;
   localparam logic [AMP_W-1:0] AMP_NORMAL_RST = AMP_W'(1700);
   localparam logic [AMP_W-1:0] AMP_LOUD_RST   = AMP_W'(2500);

   // sine table: magnitudes of the first quarter wave, entries 1..QUARTER
   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int SINE_AW          = $clog2(SINE_TABLE_DEPTH);
   localparam int SINE_QW_AW       = SINE_AW - 2;
   localparam int SINE_QUARTER     = SINE_TABLE_DEPTH / 4;
   localparam int SINE_MAG_W       = 16;
   localparam int SINE_W           = SINE_MAG_W + 1;

   localparam logic [63:0] KC1 = 64'd1686629713;
   localparam logic [63:0] KC3 = 64'd693598668;
   localparam logic [63:0] KC5 = 64'd85569306;
   localparam logic [63:0] KC7 = 64'd5026995;
   localparam logic [63:0] KC9 = 64'd172273;

   typedef logic [SINE_MAG_W-1:0] sine_qw_type [SINE_QUARTER];

   // Q30 odd polynomial of sin(pi/2*u), products truncated, rounded to Q15
   function automatic sine_qw_type build_sine_qw();
      sine_qw_type t;
      logic [63:0]  u;
      logic [63:0]  u2;
      logic [63:0]  r;
      logic [63:0]  s;
      logic [63:0]  e;
      for (int j = 1; j <= SINE_QUARTER; j++) begin
         u  = 64'(j) << (30 - SINE_QW_AW);
         u2 = (u * u) >> 30;
         r  = KC9;
         r  = KC7 - ((u2 * r) >> 30);
         r  = KC5 - ((u2 * r) >> 30);
         r  = KC3 - ((u2 * r) >> 30);
         r  = KC1 - ((u2 * r) >> 30);
         s  = (u * r) >> 30;
         e  = (s + 64'd16384) >> 15;
         t[j-1] = e[SINE_MAG_W-1:0];
      end
      return t;
   endfunction

   localparam sine_qw_type SINE_QW = build_sine_qw();

   // lane arithmetic
   localparam int EAMP_W  = LEVEL_W + 2;
   localparam int PROD_W  = EAMP_W + SINE_W - 1;
   localparam int SUM_W   = PROD_W + $clog2(VOICES);
   localparam int PAIRS   = (VOICES + 1) / 2;
   localparam int PAIR_W  = PROD_W + 1;

   // product -> pair -> sum
   localparam int SETTLE_CYCLES = 3;
   localparam int SETTLE_CNT_W  = $clog2(SETTLE_CYCLES);

   // divider: quotient known to fit DIV_Q_W bits
   localparam int DIV_Q_W   = 16;
   localparam int DIV_D_W   = 32;
   localparam int DIV_N_W   = DIV_D_W + DIV_Q_W;
   localparam int DIV_CNT_W = $clog2(DIV_Q_W);

   // release ramp 4*a*tick
   localparam int RAMP_W = AMP_W + TICK_W + 2;

   // soft clip
   localparam int CLIP_FRAC   = 15;
   localparam int KNEE_LO     = 30000;
   localparam int KNEE_HI     = 100000;
   localparam int KNEE_NUM    = 2767;
   localparam int KNEE_DEN    = 70000;
   localparam int FULL_SCALE  = 32767;
   localparam int KNEE_Q_W    = 32;
   localparam int KNEE_NUM_W  = 12;
   localparam int KNEE_PROD_W = KNEE_Q_W + KNEE_NUM_W;
   localparam int Y_W         = 15;
   localparam logic [KNEE_Q_W-1:0] KNEE_LO_Q  = KNEE_Q_W'(64'(KNEE_LO) << CLIP_FRAC);
   localparam logic [KNEE_Q_W-1:0] KNEE_HI_Q  = KNEE_Q_W'(64'(KNEE_HI) << CLIP_FRAC);

   // knee divide by 70000*2^15 = 4375*2^19: drop 19 bits (exact under floor),
   // then multiply by ceil(2^37/4375); exact for the 24-bit reduced numerator
   localparam int KNEE_PRE_SHIFT   = CLIP_FRAC + 4;
   localparam int KNEE_RED_W       = 24;
   localparam int KNEE_RECIP_W     = 25;
   localparam int KNEE_RECIP_SHIFT = 37;
   localparam int KNEE_MUL_W       = KNEE_RED_W + KNEE_RECIP_W;
   localparam int KNEE_QUO_W       = KNEE_MUL_W - KNEE_RECIP_SHIFT;
   localparam logic [KNEE_RECIP_W-1:0] KNEE_RECIP = KNEE_RECIP_W'(31414618);

   typedef struct packed {
      logic load;
      logic tick_zero;
      logic rest;
      logic advance;
   } lane_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RAMP,
      ST_RAMP_CHK,
      ST_RAMP_DIV,
      ST_SETTLE,
      ST_CLIP,
      ST_KNEE,
      ST_KNEE_DIV,
      ST_DONE
   } fsm_state_type;

endpackage

### sv/fvs_lane.sv
// One oscillator lane: phase accumulator, quarter-wave lookup, amplitude multiply.
module fvs_lane (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fvs_pkg::lane_ctl_type                ctl,
   input  logic        [fvs_pkg::INC_W-1:0]     inc,
   input  logic signed [fvs_pkg::EAMP_W-1:0]    amp,
   output logic signed [fvs_pkg::PROD_W-1:0]    prod
);
   import fvs_pkg::*;

   logic        [PHASE_W-1:0]    phase_ff, phase_in;
   logic        [INC_W-1:0]      held_ff, held_in;
   logic        [INC_W-1:0]      rel_ff, rel_in;
   logic        [INC_W-1:0]      rel_next;
   logic signed [SINE_W-1:0]     sine_ff, sine_in;
   logic signed [PROD_W-1:0]     prod_ff, prod_in;

   logic [SINE_AW-1:0]     idx;
   logic [1:0]             quad;
   logic [SINE_QW_AW-1:0]  qpos;
   logic [SINE_MAG_W-1:0]  mag;

   always_comb begin
      rel_next = ctl.tick_zero ? held_ff : rel_ff;
      phase_in = phase_ff;
      held_in  = held_ff;
      rel_in   = rel_ff;
      if (ctl.load) begin
         rel_in  = rel_next;
         held_in = inc;
         if (ctl.rest) begin
            // rest: ring on at half the previous note's increment
            phase_in = phase_ff + PHASE_W'(rel_next >> 1);
         end
      end else if (ctl.advance) begin
         phase_in = phase_ff + PHASE_W'(held_ff);
      end
   end

   // top phase bits index the table; fold into the first quarter
   always_comb begin
      idx  = phase_ff[PHASE_W-1 -: SINE_AW];
      quad = idx[SINE_AW-1 -: 2];
      qpos = idx[SINE_QW_AW-1:0];
      if (quad[0]) begin
         mag = SINE_QW[~qpos];
      end else if (qpos == '0) begin
         mag = '0;
      end else begin
         mag = SINE_QW[qpos - SINE_QW_AW'(1)];
      end
      sine_in = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      prod_in = PROD_W'(amp) * PROD_W'(sine_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         held_ff  <= '0;
         rel_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         rel_ff   <= rel_in;
      end
   end

   always_ff @(posedge clock) begin
      sine_ff <= sine_in;
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

### sv/fvs_merge.sv
// Registered two-level adder tree over the lane products.
module fvs_merge (
   input  logic                                 clock,
   input  logic signed [fvs_pkg::PROD_W-1:0]    prod [fvs_pkg::VOICES],
   output logic signed [fvs_pkg::SUM_W-1:0]     sum
);
   import fvs_pkg::*;

   logic signed [PAIR_W-1:0] pair_ff [PAIRS];
   logic signed [PAIR_W-1:0] pair_in [PAIRS];
   logic signed [SUM_W-1:0]  sum_ff, sum_in;

   for (genvar p = 0; p < PAIRS; p++) begin : g_pair
      if (2 * p + 1 < VOICES) begin : g_two
         assign pair_in[p] = PAIR_W'(prod[2*p]) + PAIR_W'(prod[2*p+1]);
      end else begin : g_one
         assign pair_in[p] = PAIR_W'(prod[2*p]);
      end
   end

   always_comb begin
      sum_in = '0;
      for (int p = 0; p < PAIRS; p++) begin
         sum_in = sum_in + SUM_W'(pair_ff[p]);
      end
   end

   always_ff @(posedge clock) begin
      pair_ff <= pair_in;
      sum_ff  <= sum_in;
   end

   assign sum = sum_ff;

endmodule

### sv/fvs_div.sv
// Restoring divider, one quotient bit per cycle; quotient must fit DIV_Q_W bits.
module fvs_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [fvs_pkg::DIV_N_W-1:0]     num,
   input  logic [fvs_pkg::DIV_D_W-1:0]     den,
   output logic                            done,
   output logic [fvs_pkg::DIV_Q_W-1:0]     quo
);
   import fvs_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIV_D_W-1:0]    rem_ff, rem_in;
   logic [DIV_D_W-1:0]    den_ff, den_in;
   logic [DIV_Q_W-1:0]    bits_ff, bits_in;
   logic [DIV_D_W:0]      trial;
   logic                  ge;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      bits_in = bits_ff;
      // numerator bits shift out the top of bits_ff, quotient bits shift in below
      trial   = {rem_ff, bits_ff[DIV_Q_W-1]};
      ge      = trial >= {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = num[DIV_N_W-1:DIV_Q_W];
         bits_in = num[DIV_Q_W-1:0];
         den_in  = den;
      end else if (busy_ff) begin
         rem_in  = ge ? DIV_D_W'(trial - {1'b0, den_ff}) : trial[DIV_D_W-1:0];
         bits_in = {bits_ff[DIV_Q_W-2:0], ge};
         cnt_in  = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_Q_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      bits_ff <= bits_in;
   end

   assign done = done_ff;
   assign quo  = bits_ff;

endmodule

### sv/five_voice_sine_synth.sv
// Top level of the five-voice additive sine synth: control, config port, lanes and merge.
//
// Each input transfer is one audio sample tick and yields exactly one 16-bit signed sample.
// Five oscillator lanes (32-bit phase accumulators over a 1024-point sine, held as one
// quarter wave) run side by side; a registered adder tree merges them, and a soft clip
// maps the Q15 sum to -32767..32767 (linear below 30000, a 2767/70000 knee up to 100000,
// saturation above). A tick whose voice-0 increment is zero is a rest: the voices ring on
// at half the increments of the previous note while the amplitude ramps down by
// 4*amp*tick_index/note_span (note_span 0 counts as 1). tick_index 0 starts a note.
// The block takes one item at a time: a plain tick goes through the ramp, settle, clip and
// done states before the next one is let in. A rest tick whose ramp level is below the
// amplitude adds a check of that level and, unless it saturates, a divide; a sum in the knee
// passes the knee states. The ramp extra comes from a 16-step restoring divider; the
// knee uses a reciprocal multiply. A finished sample waits in the output register, so
// the next tick is taken while it is still unclaimed. amp_normal (byte address 0) and
// amp_loud (address 4) are 12-bit registers on the config port and are read back there;
// write them only while the block is idle.
module five_voice_sine_synth (
   input  logic                                clock,
   input  logic                                reset,
   // tdata: inc_v0[30:0], inc_v1, inc_v2, inc_v3, inc_v4, tick_index[17:0],
   //        note_span[17:0], one zero pad bit at the top
   input  logic [fvs_pkg::REQ_DATA_W-1:0]      req_tdata,
   // tuser: loud
   input  logic [fvs_pkg::REQ_USER_W-1:0]      req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: sample (signed)
   output logic [fvs_pkg::SAMPLE_W-1:0]        rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [fvs_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [fvs_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [fvs_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);
   import fvs_pkg::*;

   // ---------------------------------------------------------------- config
   logic [AMP_W-1:0] amp_normal_ff, amp_normal_in;
   logic [AMP_W-1:0] amp_loud_ff, amp_loud_in;
   logic             csr_write;
   csr_reg_type      csr_reg;

   assign csr_reg    = csr_reg_type'(csr_paddr[CSR_ADDR_W-1]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      amp_normal_in = amp_normal_ff;
      amp_loud_in   = amp_loud_ff;
      csr_prdata    = '0;
      unique case (csr_reg)
         CSR_AMP_NORMAL: begin
            csr_prdata = CSR_DATA_W'(amp_normal_ff);
            if (csr_write) begin
               amp_normal_in = csr_pwdata[AMP_W-1:0];
            end
         end
         CSR_AMP_LOUD: begin
            csr_prdata = CSR_DATA_W'(amp_loud_ff);
            if (csr_write) begin
               amp_loud_in = csr_pwdata[AMP_W-1:0];
            end
         end
      endcase
   end

   // ---------------------------------------------------------------- input fields
   logic [INC_W-1:0]  inc_arr [VOICES];
   logic [TICK_W-1:0] req_tick;
   logic [TICK_W-1:0] req_span;
   logic              req_loud;
   logic              accept;

   for (genvar v = 0; v < VOICES; v++) begin : g_inc
      if (v < INC_FIELDS) begin : g_field
         assign inc_arr[v] = req_tdata[v*INC_W +: INC_W];
      end else begin : g_extra
         // voices beyond the input fields stay silent
         assign inc_arr[v] = '0;
      end
   end

   assign req_tick = req_tdata[REQ_TICK_LSB +: TICK_W];
   assign req_span = req_tdata[REQ_SPAN_LSB +: TICK_W];
   assign req_loud = req_tuser[0];

   // ---------------------------------------------------------------- control state
   fsm_state_type            state_ff, state_in;
   logic                     ready_ff, ready_in;
   logic [AMP_W-1:0]         a_ff, a_in;
   logic [TICK_W-1:0]        tick_ff, tick_in;
   logic [TICK_W-1:0]        span_ff, span_in;
   logic                     rest_ff, rest_in;
   logic [LEVEL_W-1:0]       level_ff, level_in;
   logic [SETTLE_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [RAMP_W-1:0]        num_ff, num_in;
   logic [KNEE_PROD_W-1:0]   knee_ff, knee_in;
   logic [KNEE_MUL_W-1:0]    recip_ff, recip_in;
   logic                     neg_ff, neg_in;
   logic [Y_W-1:0]           y_ff, y_in;
   logic                     rsp_tvalid_ff, rsp_tvalid_in;
   logic [SAMPLE_W-1:0]      rsp_tdata_ff, rsp_tdata_in;

   logic signed [EAMP_W-1:0] amp;
   logic signed [SUM_W-1:0]  sum;
   logic [SUM_W-1:0]         mag;
   logic [KNEE_Q_W-1:0]      knee_diff;
   lane_ctl_type             lane_ctl;

   logic                     div_start;
   logic [DIV_N_W-1:0]       div_num;
   logic [DIV_D_W-1:0]       div_den;
   logic                     div_done;
   logic [DIV_Q_W-1:0]       div_quo;

   assign accept = req_tvalid & ready_ff;

   // effective amplitude; may go negative once the ramp passes the base level
   assign amp = $signed(EAMP_W'(a_ff)) - $signed(EAMP_W'(level_ff));

   assign mag       = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
   assign knee_diff = KNEE_Q_W'(mag - SUM_W'(KNEE_LO_Q));

   // the divider serves the release ramp only
   assign div_num = DIV_N_W'(num_ff);
   assign div_den = DIV_D_W'(span_ff);

   always_comb begin
      lane_ctl.load      = accept;
      lane_ctl.tick_zero = req_tick == '0;
      lane_ctl.rest      = inc_arr[0] == '0;
      // phases step by the note increments once the sum has been taken
      lane_ctl.advance   = state_ff == ST_CLIP;
   end

   always_comb begin
      state_in      = state_ff;
      a_in          = a_ff;
      tick_in       = tick_ff;
      span_in       = span_ff;
      rest_in       = rest_ff;
      level_in      = level_ff;
      cnt_in        = '0;
      num_in        = num_ff;
      knee_in       = knee_ff;
      recip_in      = recip_ff;
      neg_in        = neg_ff;
      y_in          = y_ff;
      div_start     = 1'b0;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               a_in    = req_loud ? amp_loud_ff : amp_normal_ff;
               tick_in = req_tick;
               span_in = (req_span == '0) ? TICK_W'(1) : req_span;
               rest_in = inc_arr[0] == '0;
               if (req_tick == '0) begin
                  level_in = '0;
               end
               state_in = ST_RAMP;
            end
         end
         ST_RAMP: begin
            num_in = (RAMP_W'(a_ff) * RAMP_W'(tick_ff)) << 2;
            if (rest_ff && (LEVEL_W'(a_ff) > level_ff)) begin
               state_in = ST_RAMP_CHK;
            end else begin
               state_in = ST_SETTLE;
            end
         end
         ST_RAMP_CHK: begin
            // a quotient past 16 bits saturates without dividing
            if (TICK_W'(num_ff[RAMP_W-1:DIV_Q_W]) >= span_ff) begin
               level_in = '1;
               state_in = ST_SETTLE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_RAMP_DIV;
            end
         end
         ST_RAMP_DIV: begin
            if (div_done) begin
               level_in = LEVEL_W'(div_quo);
               state_in = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            // wait for product, pair and sum registers to see the new amplitude
            cnt_in = cnt_ff + SETTLE_CNT_W'(1);
            if (cnt_ff == SETTLE_CNT_W'(SETTLE_CYCLES - 1)) begin
               state_in = ST_CLIP;
            end
         end
         ST_CLIP: begin
            neg_in = sum[SUM_W-1];
            if (mag >= SUM_W'(KNEE_HI_Q)) begin
               y_in     = Y_W'(FULL_SCALE);
               state_in = ST_DONE;
            end else if (mag >= SUM_W'(KNEE_LO_Q)) begin
               knee_in  = KNEE_PROD_W'(knee_diff) * KNEE_PROD_W'(KNEE_NUM);
               state_in = ST_KNEE;
            end else begin
               y_in     = mag[CLIP_FRAC +: Y_W];
               state_in = ST_DONE;
            end
         end
         ST_KNEE: begin
            // reciprocal multiply for the constant knee divisor
            recip_in = KNEE_MUL_W'(knee_ff[KNEE_PRE_SHIFT +: KNEE_RED_W]) *
                       KNEE_MUL_W'(KNEE_RECIP);
            state_in = ST_KNEE_DIV;
         end
         ST_KNEE_DIV: begin
            y_in     = Y_W'(KNEE_LO) + Y_W'(recip_ff[KNEE_RECIP_SHIFT +: KNEE_QUO_W]);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tdata_in  = neg_ff ? SAMPLE_W'(-SAMPLE_W'(y_ff)) : SAMPLE_W'(y_ff);
               rsp_tvalid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      ready_in = state_in == ST_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ready_ff      <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         level_ff      <= '0;
         cnt_ff        <= '0;
         amp_normal_ff <= AMP_NORMAL_RST;
         amp_loud_ff   <= AMP_LOUD_RST;
      end else begin
         state_ff      <= state_in;
         ready_ff      <= ready_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         level_ff      <= level_in;
         cnt_ff        <= cnt_in;
         amp_normal_ff <= amp_normal_in;
         amp_loud_ff   <= amp_loud_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff         <= a_in;
      tick_ff      <= tick_in;
      span_ff      <= span_in;
      rest_ff      <= rest_in;
      num_ff       <= num_in;
      knee_ff      <= knee_in;
      recip_ff     <= recip_in;
      neg_ff       <= neg_in;
      y_ff         <= y_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign req_tready = ready_ff;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // ---------------------------------------------------------------- datapath
   logic signed [PROD_W-1:0] prod_arr [VOICES];

   for (genvar v = 0; v < VOICES; v++) begin : g_lane
      fvs_lane u_lane (
         .clock (clock),
         .reset (reset),
         .ctl   (lane_ctl),
         .inc   (inc_arr[v]),
         .amp   (amp),
         .prod  (prod_arr[v])
      );
   end

   fvs_merge u_merge (
      .clock (clock),
      .prod  (prod_arr),
      .sum   (sum)
   );

   fvs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

endmodule

### sv/fvs_checker.sv
// Port-level checks of the sine synth, bound to its top level.
`include "five_voice_sine_synth_macros.svh"

module fvs_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [fvs_pkg::SAMPLE_W-1:0]        rsp_tdata,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready
);
   import fvs_pkg::*;

   // a stalled sample holds
   `FVS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "sample changed while stalled")

   // the clip never reaches the most negative code
   `FVS_ASSERT_SAME(a_rsp_range, rsp_tvalid, rsp_tdata != SAMPLE_W'(1 << (SAMPLE_W - 1)), "sample out of range")

   // one tick at a time: no transfer in the cycle after a transfer
   `FVS_ASSERT_NEXT(a_req_gap, req_tvalid && req_tready, !req_tready, "ready right after a transfer")

   // no sample pending straight out of reset
   `FVS_ASSERT_SAME(a_rsp_reset, $past(reset), !rsp_tvalid, "sample pending after reset")

endmodule

bind five_voice_sine_synth fvs_checker u_fvs_checker (.*);

### tb/five_voice_sine_synth_checker.sv
// Checker for the sine synth: predicts every sample from the stream and register traffic.
module five_voice_sine_synth_checker
   import fvs_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic [REQ_DATA_W-1:0]      req_tdata,
   input  logic [REQ_USER_W-1:0]      req_tuser,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [SAMPLE_W-1:0]        rsp_tdata,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [CSR_DATA_W-1:0]      csr_pwdata,
   input  logic [CSR_DATA_W-1:0]      csr_prdata,
   input  logic                       csr_pready,
   output int                         fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LUT_DEPTH  = 1024;
   localparam int LUT_AW     = 10;
   localparam int OSC_N      = 5;

   // Q30 odd Taylor terms of sin(pi/2*u)
   localparam logic [63:0] TERM1 = 64'd1686629713;
   localparam logic [63:0] TERM3 = 64'd693598668;
   localparam logic [63:0] TERM5 = 64'd85569306;
   localparam logic [63:0] TERM7 = 64'd5026995;
   localparam logic [63:0] TERM9 = 64'd172273;

   // soft clip bends, Q15
   localparam logic [63:0] BEND_LO  = 64'd30000 << 15;
   localparam logic [63:0] BEND_HI  = 64'd100000 << 15;
   localparam logic [63:0] BEND_DEN = 64'd70000 << 15;

   int            sine_lut [LUT_DEPTH];
   logic [11:0]   amp_normal_q;
   logic [11:0]   amp_loud_q;
   logic [31:0]   phase_acc [OSC_N];
   logic [31:0]   note_inc [OSC_N];
   logic [31:0]   ring_inc [OSC_N];
   logic [15:0]   ramp_level;
   logic [15:0]   pending_samples [$];
   logic [15:0]   expected_sample;
   logic [31:0]   expected_reg;
   int            mismatches = 0;

   function automatic int sine_entry(int k);
      logic [63:0] u;
      logic [63:0] u2;
      logic [63:0] r;
      logic [63:0] s;
      logic [63:0] e;
      int          quadrant;
      quadrant = k >> 8;
      u = 64'(k % 256) << 22;
      if (quadrant % 2 == 1) u = 64'h4000_0000 - u;
      u2 = (u * u) >> 30;
      r  = TERM9;
      r  = TERM7 - ((u2 * r) >> 30);
      r  = TERM5 - ((u2 * r) >> 30);
      r  = TERM3 - ((u2 * r) >> 30);
      r  = TERM1 - ((u2 * r) >> 30);
      s  = (u * r) >> 30;
      e  = (s + 64'd16384) >> 15;
      return (quadrant >= 2) ? -int'(e) : int'(e);
   endfunction

   initial begin
      for (int k = 0; k < LUT_DEPTH; k++) sine_lut[k] = sine_entry(k);
   end

   function automatic logic [15:0] clip_sample(longint acc);
      logic [63:0] mag;
      logic [63:0] y;
      mag = (acc < 0) ? 64'(-acc) : 64'(acc);
      if (mag >= BEND_HI) y = 64'd32767;
      else if (mag >= BEND_LO) y = 64'd30000 + ((mag - BEND_LO) * 64'd2767) / BEND_DEN;
      else y = mag >> 15;
      return (acc < 0) ? 16'(-y) : 16'(y);
   endfunction

   task automatic report(string what, longint want, longint got);
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
   endtask

   // one tick: ramp and phase update, then the expected sample
   task automatic predict_tick(input logic [REQ_DATA_W-1:0] d, input logic loud);
      logic [31:0] inc [OSC_N];
      logic [17:0] tick;
      logic [31:0] span;
      logic [11:0] a;
      logic [63:0] ramp;
      longint      eff;
      longint      acc;
      tick = d[REQ_TICK_LSB +: TICK_W];
      span = 32'(d[REQ_SPAN_LSB +: TICK_W]);
      if (span == 0) span = 1;
      a = loud ? amp_loud_q : amp_normal_q;
      for (int i = 0; i < OSC_N; i++) inc[i] = 32'(d[i*INC_W +: INC_W]);
      if (tick == 0) begin
         for (int i = 0; i < OSC_N; i++) ring_inc[i] = note_inc[i];
         ramp_level = '0;
      end
      for (int i = 0; i < OSC_N; i++) note_inc[i] = inc[i];
      if (inc[0] == 0) begin
         for (int i = 0; i < OSC_N; i++) phase_acc[i] += ring_inc[i] >> 1;
         if (32'(a) > 32'(ramp_level)) begin
            ramp = (64'd4 * a * tick) / span;
            ramp_level = (ramp > 64'd65535) ? 16'hFFFF : ramp[15:0];
         end
      end
      eff = longint'(a) - longint'(ramp_level);
      acc = 0;
      for (int i = 0; i < OSC_N; i++)
         acc += eff * longint'(sine_lut[phase_acc[i][31 -: LUT_AW]]);
      pending_samples.push_back(clip_sample(acc));
      for (int i = 0; i < OSC_N; i++) phase_acc[i] += inc[i];
   endtask

   always @(posedge clock) begin
      if (reset) begin
         amp_normal_q = AMP_NORMAL_RST;
         amp_loud_q   = AMP_LOUD_RST;
         for (int i = 0; i < OSC_N; i++) begin
            phase_acc[i] = '0;
            note_inc[i]  = '0;
            ring_inc[i]  = '0;
         end
         ramp_level = '0;
         pending_samples.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (csr_reg_type'(csr_paddr[2]))
                  CSR_AMP_NORMAL: amp_normal_q = csr_pwdata[11:0];
                  CSR_AMP_LOUD:   amp_loud_q   = csr_pwdata[11:0];
               endcase
            end else begin
               expected_reg = (csr_reg_type'(csr_paddr[2]) == CSR_AMP_LOUD) ?
                              32'(amp_loud_q) : 32'(amp_normal_q);
               if (csr_prdata !== expected_reg) report("readback", expected_reg, csr_prdata);
            end
         end
         // results first: a tick taken this edge cannot have produced one yet
         if (rsp_tvalid && rsp_tready) begin
            if (pending_samples.size() == 0) begin
               report("unexpected sample", 0, $signed(rsp_tdata));
            end else begin
               expected_sample = pending_samples.pop_front();
               if (rsp_tdata !== expected_sample)
                  report("sample", $signed(expected_sample), $signed(rsp_tdata));
            end
         end
         if (req_tvalid && req_tready) predict_tick(req_tdata, req_tuser[0]);
      end
      fail_count = mismatches + pending_samples.size();
   end

endmodule

### tb/tb_top.sv
// Stimulus and verdict for the five-voice sine synth testbench.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import fvs_pkg::*;

   localparam int     DRAIN_CYCLES = 60;
   localparam int     HOLD_CYCLES  = 400;      // long sink back-pressure
   localparam longint RUN_LIMIT_NS = 8_000_000;

   localparam logic [INC_W-1:0] INC_MAX     = '1;
   localparam logic [INC_W-1:0] INC_QUARTER = 31'h4000_0000;
   localparam logic [INC_W-1:0] INC_EIGHTH  = 31'h2000_0000;
   localparam logic [INC_W-1:0] INC_ODD     = 31'h5555_5555;
   localparam logic [INC_W-1:0] INC_EVEN    = 31'h2AAA_AAAA;
   localparam logic [TICK_W-1:0] TICK_MAX   = '1;

   // One tick as it goes on the wire; inc[0] lands in the lowest tdata bits.
   typedef struct packed {
      logic [TICK_W-1:0]             span;
      logic [TICK_W-1:0]             tick;
      logic [VOICES-1:0][INC_W-1:0]  inc;
      logic                          loud;
   } tick_item_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic [REQ_USER_W-1:0]  req_tuser = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [SAMPLE_W-1:0]    rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   int   fail_count;
   int   ticks_sent = 0;       // input transfers, counted by the sender
   int   samples_taken = 0;    // output transfers, counted by the sink
   logic steady = 1'b0;        // no idling on either side while set
   logic hold_wanted = 1'b0;   // ask the sink for its one long hold
   logic hold_served = 1'b0;
   int   hold_left = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   five_voice_sine_synth dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   five_voice_sine_synth_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count)
   );

   // Sink side: random ~24% idle, none while steady, and one long hold that
   // it counts down itself. The sender keeps offering meanwhile, so the
   // output register fills and req_tready drops.
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) samples_taken <= samples_taken + 1;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_wanted && !hold_served) begin
         hold_served <= 1'b1;
         hold_left   <= HOLD_CYCLES;
         rsp_tready  <= 1'b0;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= 24);
      end
   end

   function automatic tick_item_type mk_tick(logic [INC_W-1:0] i0, logic [INC_W-1:0] i1,
                                             logic [INC_W-1:0] i2, logic [INC_W-1:0] i3,
                                             logic [INC_W-1:0] i4, logic loud,
                                             logic [TICK_W-1:0] tick, logic [TICK_W-1:0] span);
      tick_item_type t;
      t.inc  = {i4, i3, i2, i1, i0};
      t.loud = loud;
      t.tick = tick;
      t.span = span;
      return t;
   endfunction

   // Mix of full-range, low, mid and near-max increments.
   function automatic logic [INC_W-1:0] next_inc();
      case ($urandom_range(3))
         0:       return INC_W'($urandom);
         1:       return INC_W'($urandom_range(1, 1 << 22));
         2:       return INC_W'($urandom_range(1 << 26, 1 << 29));
         default: return ~INC_W'($urandom_range(1 << 16));
      endcase
   endfunction

   // Source side: random gaps before each tick (none while steady). Valid is
   // only lowered in a gap or at a drain, so back-to-back ticks keep it high.
   task automatic send_tick(input tick_item_type t);
      while (!steady && $urandom_range(99) < 24) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= REQ_DATA_W'({t.span, t.tick, t.inc});
      req_tuser  <= t.loud;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ticks_sent++;
   endtask

   // Wait for every sample, then let the block settle.
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (samples_taken != ticks_sent) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register write followed by a readback of the same register.
   task automatic write_level(input csr_reg_type idx, input logic [AMP_W-1:0] level);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= CSR_DATA_W'(level);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_levels(input logic [AMP_W-1:0] normal, input logic [AMP_W-1:0] loud);
      wait_drain();
      write_level(CSR_AMP_NORMAL, normal);
      write_level(CSR_AMP_LOUD, loud);
   endtask

   // Random traffic, mostly well-formed notes and rests (tick 0..len-1 with
   // span = len), the rest broken runs and single noise ticks.
   task automatic run_notes(input int count);
      tick_item_type t;
      int            done;
      int            len;
      int            first;
      int            kind;
      done = 0;
      while (done < count) begin
         kind = $urandom_range(99);
         for (int v = 0; v < VOICES; v++) t.inc[v] = next_inc();
         t.loud = $urandom_range(1);
         len = ($urandom_range(9) == 0) ? $urandom_range(60, 300) : $urandom_range(1, 24);
         if (kind < 10) begin
            // noise: any tick and span, including span 0 and huge ramps
            if ($urandom_range(3) == 0) t.inc[0] = '0;
            t.tick = TICK_W'($urandom);
            t.span = ($urandom_range(3) == 0) ? TICK_W'($urandom_range(3)) : TICK_W'($urandom);
            send_tick(t);
            done++;
         end else begin
            if (kind < 35) t.inc[0] = '0;
            else if (t.inc[0] == '0) t.inc[0] = INC_W'(1);
            t.span = ($urandom_range(9) == 0) ? TICK_W'($urandom_range(3)) : TICK_W'(len);
            first  = ($urandom_range(9) == 0) ? $urandom_range(len - 1) : 0;
            for (int k = first; k < len && done < count; k++) begin
               t.tick = TICK_W'(k);
               if ($urandom_range(19) == 0) t.loud = ~t.loud;
               send_tick(t);
               done++;
            end
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed ticks at reset levels, phases start at zero.
      // Note at eighth-turn steps, then a rest at tick 0 with span 0.
      send_tick(mk_tick(INC_EIGHTH, INC_EIGHTH, INC_EIGHTH, INC_EIGHTH, INC_EIGHTH,
                        1'b0, '0, TICK_MAX));
      send_tick(mk_tick('0, '0, '0, '0, '0, 1'b0, '0, '0));
      // Ramp overflow: level saturates, amplitude goes negative, all voices at
      // the sine peak, so the sample saturates.
      send_tick(mk_tick('0, '0, '0, '0, '0, 1'b0, TICK_MAX, 18'd1));
      send_tick(mk_tick(INC_QUARTER, INC_QUARTER, INC_QUARTER, INC_QUARTER, '0,
                        1'b1, 18'd1, 18'd1));
      // One voice left at the peak: the sum lands in the knee.
      send_tick(mk_tick(INC_MAX, INC_MAX, INC_MAX, INC_MAX, INC_MAX, 1'b1, 18'd2, 18'd1));
      // New note clears the ramp; field extremes.
      send_tick(mk_tick(31'd1, 31'd1, 31'd1, 31'd1, 31'd1, 1'b1, '0, TICK_MAX));
      send_tick(mk_tick(INC_MAX, INC_MAX, INC_MAX, INC_MAX, INC_MAX, 1'b0, TICK_MAX, TICK_MAX));
      send_tick(mk_tick('0, INC_MAX, INC_MAX, INC_MAX, INC_MAX, 1'b0, TICK_MAX, TICK_MAX));
      send_tick(mk_tick('0, INC_EVEN, INC_ODD, INC_EVEN, INC_ODD, 1'b1, 18'h2AAAA, 18'h15555));
      send_tick(mk_tick(INC_ODD, INC_EVEN, INC_ODD, INC_EVEN, INC_ODD, 1'b0, 18'h15555, 18'h2AAAA));
      // Short note, then a short rest that ramps past the amplitude.
      send_tick(mk_tick(INC_EVEN, INC_ODD, INC_EVEN, INC_ODD, INC_EVEN, 1'b1, '0, 18'd3));
      send_tick(mk_tick('0, INC_QUARTER, INC_EIGHTH, INC_MAX, 31'd1, 1'b0, 18'd1, 18'd3));
      send_tick(mk_tick('0, INC_QUARTER, INC_EIGHTH, INC_MAX, 31'd1, 1'b0, 18'd2, 18'd3));
      send_tick(mk_tick('0, INC_QUARTER, INC_EIGHTH, INC_MAX, 31'd1, 1'b1, 18'd3, 18'd3));

      // Random phases, each at its own pair of levels.
      set_levels(12'd4095, 12'd4095);
      run_notes(120);
      hold_wanted = 1'b1;
      run_notes(220);

      set_levels(12'd0, 12'd4095);
      steady = 1'b1;
      run_notes(340);
      steady = 1'b0;

      set_levels(12'd4095, 12'd0);
      run_notes(340);

      set_levels(AMP_W'($urandom), AMP_W'($urandom));
      run_notes(340);

      set_levels(12'd1, 12'd2);
      run_notes(340);

      wait_drain();
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Hang guard, several times the slowest legal run.
   initial begin
      #(RUN_LIMIT_NS);
      $display("TEST FAILED");
      $finish;
   end

endmodule

### sim.f
+incdir+sv
sv/fvs_pkg.sv
sv/fvs_lane.sv
sv/fvs_merge.sv
sv/fvs_div.sv
sv/five_voice_sine_synth.sv
sv/fvs_checker.sv
tb/five_voice_sine_synth_checker.sv
tb/tb_top.sv
